@@ rtl/q4mv_pkg.sv @@
package q4mv_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned ScaleW = 16;
	localparam int unsigned WgtW   = 128;
	localparam int unsigned ActW   = 256;
	localparam int unsigned DotW   = 17;
	localparam int unsigned LaneW  = 15;
	localparam int unsigned ProdW  = 27;
	localparam int unsigned MagW   = 56;
	localparam int unsigned NumSteps = 4;
	localparam int unsigned StepW  = 2;

	localparam logic [4:0] ExpSpecial = 5'h1F;
	localparam logic signed [WordW-1:0] SumMax = {1'b0, {(WordW-1){1'b1}}};
	localparam logic signed [WordW-1:0] SumMin = {1'b1, {(WordW-1){1'b0}}};

	typedef struct packed {
		logic             load;
		logic             dot_step;
		logic [StepW-1:0] dot_idx;
		logic             mul;
		logic             shift;
		logic             acc;
	} q4mv_cmd_t;

	typedef struct packed {
		logic last;
		logic out_busy;
	} q4mv_stat_t;

endpackage

@@ rtl/q4mv_ctrl.sv @@
module q4mv_ctrl
	import q4mv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       blk_valid,
	output logic       blk_ready,
	input  q4mv_stat_t stat,
	output q4mv_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_MUL,
		ST_SHIFT,
		ST_ACC
	} state_t;

	state_t           state_q;
	logic [StepW-1:0] step_q;
	logic             acc_go;

	assign blk_ready = (state_q == ST_IDLE);
	assign acc_go    = (state_q == ST_ACC) && !(stat.last && stat.out_busy);

	always_comb begin
		cmd          = '0;
		cmd.load     = blk_valid && blk_ready;
		cmd.dot_step = (state_q == ST_DOT);
		cmd.dot_idx  = step_q;
		cmd.mul      = (state_q == ST_MUL);
		cmd.shift    = (state_q == ST_SHIFT);
		cmd.acc      = acc_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (blk_valid) state_q <= ST_DOT;
				end
				ST_DOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == StepW'(NumSteps - 1)) state_q <= ST_MUL;
				end
				ST_MUL:   state_q <= ST_SHIFT;
				ST_SHIFT: state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_go) state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/q4mv_dp.sv @@
module q4mv_dp
	import q4mv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  q4mv_cmd_t               cmd,
	output q4mv_stat_t              stat,
	input  logic [ScaleW-1:0]       scale_bits,
	input  logic [WordW-1:0]        weights_lo,
	input  logic [WordW-1:0]        weights_hi,
	input  logic [WordW-1:0]        act_word0,
	input  logic [WordW-1:0]        act_word1,
	input  logic [WordW-1:0]        act_word2,
	input  logic [WordW-1:0]        act_word3,
	input  logic                    last_block,
	output logic                    sum_valid,
	input  logic                    sum_ready,
	output logic signed [WordW-1:0] row_sum,
	output logic                    overflowed,
	output logic                    invalid_scale
);

	// 8 lanes: nibble i of w pairs with activation byte i of a
	function automatic logic signed [LaneW-1:0] lane_sum(logic [31:0] w, logic [63:0] a);
		logic signed [4:0]       wn;
		logic signed [7:0]       av;
		logic signed [12:0]      p;
		logic signed [LaneW-1:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			wn = $signed({1'b0, w[4*i +: 4]}) - 5'sd8;
			av = $signed(a[8*i +: 8]);
			p  = 13'(wn) * 13'(av);
			s  = s + LaneW'(p);
		end
		return s;
	endfunction

	logic [ScaleW-1:0]       scale_q;
	logic [WgtW-1:0]         wgt_q;
	logic [ActW-1:0]         act_q;
	logic                    last_q;
	logic signed [DotW-1:0]  dot_q;
	logic [ProdW-1:0]        prod_q;
	logic [4:0]              sh_q;
	logic                    neg_q;
	logic                    inv_q;
	logic signed [WordW-1:0] contrib_q;
	logic signed [WordW-1:0] acc_q;
	logic                    ovf_seen_q;
	logic                    inv_seen_q;
	logic                    out_valid_q;
	logic signed [WordW-1:0] out_sum_q;
	logic                    out_ovf_q;
	logic                    out_inv_q;

	logic [4:0]              ex;
	logic [10:0]             mant;
	logic [DotW-1:0]         mag_dot;
	logic [MagW-1:0]         mag;
	logic signed [WordW:0]   sum_w;
	logic                    ovf;
	logic signed [WordW-1:0] acc_nxt;
	logic                    ovf_nxt;
	logic                    inv_nxt;

	assign stat.last     = last_q;
	assign stat.out_busy = out_valid_q && !sum_ready;

	assign sum_valid     = out_valid_q;
	assign row_sum       = out_sum_q;
	assign overflowed    = out_ovf_q;
	assign invalid_scale = out_inv_q;

	always_comb begin
		ex = scale_q[14:10];
		if (ex == ExpSpecial) mant = '0;
		else if (ex == 5'd0)  mant = {1'b0, scale_q[9:0]};
		else                  mant = {1'b1, scale_q[9:0]};
		mag_dot = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
		mag     = MagW'(prod_q) << sh_q;
		sum_w   = {acc_q[WordW-1], acc_q} + {contrib_q[WordW-1], contrib_q};
		ovf     = sum_w[WordW] ^ sum_w[WordW-1];
		if (ovf) acc_nxt = sum_w[WordW] ? SumMin : SumMax;
		else     acc_nxt = sum_w[WordW-1:0];
		ovf_nxt = ovf_seen_q || ovf;
		inv_nxt = inv_seen_q || inv_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scale_q <= scale_bits;
			wgt_q   <= {weights_hi, weights_lo};
			act_q   <= {act_word3, act_word2, act_word1, act_word0};
			last_q  <= last_block;
			dot_q   <= '0;
		end else if (cmd.dot_step) begin
			dot_q <= dot_q + DotW'(lane_sum(wgt_q[32*cmd.dot_idx +: 32],
				act_q[64*cmd.dot_idx +: 64]));
		end
		if (cmd.mul) begin
			prod_q <= ProdW'(mant) * ProdW'(mag_dot);
			sh_q   <= (ex == 5'd0) ? 5'd0 : ex - 5'd1;
			neg_q  <= scale_q[15] ^ dot_q[DotW-1];
			inv_q  <= (ex == ExpSpecial);
		end
		if (cmd.shift) begin
			contrib_q <= neg_q ? -$signed(WordW'(mag)) : $signed(WordW'(mag));
		end
		if (cmd.acc && last_q) begin
			out_sum_q <= acc_nxt;
			out_ovf_q <= ovf_nxt;
			out_inv_q <= inv_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			ovf_seen_q  <= 1'b0;
			inv_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				if (last_q) begin
					acc_q      <= '0;
					ovf_seen_q <= 1'b0;
					inv_seen_q <= 1'b0;
				end else begin
					acc_q      <= acc_nxt;
					ovf_seen_q <= ovf_nxt;
					inv_seen_q <= inv_nxt;
				end
			end
			if (cmd.acc && last_q)         out_valid_q <= 1'b1;
			else if (sum_valid && sum_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ rtl/q4_block_matvec_row_accumulator.sv @@
// Q4 block row accumulator.
// Block channel (blk_valid/blk_ready): one quantized weight block per item,
// fp16 scale, 16 packed weight bytes, 32 signed activations, last_block.
// Sum channel (sum_valid/sum_ready): one item per row, issued on the block
// marked last: row_sum (signed, 24 fraction bits, saturated), overflowed,
// invalid_scale.
// Each block passes through accept, 4 dot-product steps of 8 lanes each,
// scale multiply, exponent shift and saturating accumulate. blk_ready is
// high only while idle, so a new block is taken only once the last is done.
// The accumulate step of a last block loads its result into the output register.
// The result sits in an output register; the next block is accepted while
// it waits. If a later last block finishes while that result is still not
// taken, the accumulate step holds until sum_ready.
// Reset clears the accumulator, both flags and the output valid bit; the
// block is ready on the first cycle after reset.
module q4_block_matvec_row_accumulator
	import q4mv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    blk_valid,
	output logic                    blk_ready,
	input  logic [ScaleW-1:0]       scale_bits,
	input  logic [WordW-1:0]        weights_lo,
	input  logic [WordW-1:0]        weights_hi,
	input  logic [WordW-1:0]        act_word0,
	input  logic [WordW-1:0]        act_word1,
	input  logic [WordW-1:0]        act_word2,
	input  logic [WordW-1:0]        act_word3,
	input  logic                    last_block,
	output logic                    sum_valid,
	input  logic                    sum_ready,
	output logic signed [WordW-1:0] row_sum,
	output logic                    overflowed,
	output logic                    invalid_scale
);

	q4mv_cmd_t  cmd;
	q4mv_stat_t stat;

	q4mv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	q4mv_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.scale_bits    (scale_bits),
		.weights_lo    (weights_lo),
		.weights_hi    (weights_hi),
		.act_word0     (act_word0),
		.act_word1     (act_word1),
		.act_word2     (act_word2),
		.act_word3     (act_word3),
		.last_block    (last_block),
		.sum_valid     (sum_valid),
		.sum_ready     (sum_ready),
		.row_sum       (row_sum),
		.overflowed    (overflowed),
		.invalid_scale (invalid_scale)
	);

endmodule
